// File: hdl/qrs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Quadratic root solver package
// Status codes and fixed-point constants shared by the solver modules.
// ----------------------------------------------------------------------------
package qrs_pkg;

   typedef enum logic [1:0] {
      ST_REAL     = 2'd0,
      ST_NEG_DISC = 2'd1,
      ST_A_ZERO   = 2'd2
   } status_type;

   localparam int STATUS_WIDTH = 2;
   localparam int ROOT_WIDTH   = 32;
   localparam int ROOT_FRAC    = 16;
   localparam logic [63:0] ROOT_POS_LIMIT = 64'h0000_0000_7fff_ffff;
   localparam logic [63:0] ROOT_NEG_LIMIT = 64'h0000_0000_8000_0000;

endpackage

`default_nettype wire

// File: hdl/qrs_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Two-entry queue
// Register queue used between pipeline sections of the solver and to hold its finished results.
// ----------------------------------------------------------------------------
module qrs_fifo
   import qrs_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  empty,
   output logic                  full
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   assign empty    = (count_ff == 2'd0);
   assign full     = (count_ff == 2'd2);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: hdl/qrs_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Solver front end
// Accepts coefficients, forms the discriminant and classifies each item.
// ----------------------------------------------------------------------------
module qrs_front
   import qrs_pkg::*;
#(
   parameter int W = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire logic signed [W-1:0]   coef_a,
   input  wire logic signed [W-1:0]   coef_b,
   input  wire logic signed [W-1:0]   coef_c,
   output logic                       full,
   input  wire logic                  down_full,
   output logic                       out_valid,
   output logic [STATUS_WIDTH+4*W:0]  out_data
);

   localparam int DW = 2 * W + 1;
   localparam int EW = 2 * W + 3;

   logic                  en;
   logic                  v1_ff, v2_ff, v3_ff;
   logic signed [W-1:0]   a1_ff, b1_ff, c1_ff;
   logic signed [W-1:0]   a2_ff, b2_ff;
   logic signed [2*W-1:0] ac_ff, bb_ff;
   logic signed [W-1:0]   a3_ff, b3_ff;
   logic [DW-1:0]         d3_ff;
   status_type            st3_ff;
   logic signed [EW-1:0]  d_full;
   status_type            st_in;

   assign en        = !down_full;
   assign full      = down_full;
   assign out_valid = v3_ff && en;
   assign out_data  = {st3_ff, a3_ff, b3_ff, d3_ff};

   always_comb begin
      d_full = EW'(bb_ff) - (EW'(ac_ff) <<< 2);
      if (a2_ff == '0) begin
         st_in = ST_A_ZERO;
      end else if (d_full[EW-1]) begin
         st_in = ST_NEG_DISC;
      end else begin
         st_in = ST_REAL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= push;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a1_ff  <= coef_a;
         b1_ff  <= coef_b;
         c1_ff  <= coef_c;
         ac_ff  <= a1_ff * c1_ff;
         bb_ff  <= b1_ff * b1_ff;
         a2_ff  <= a1_ff;
         b2_ff  <= b1_ff;
         a3_ff  <= a2_ff;
         b3_ff  <= b2_ff;
         d3_ff  <= d_full[DW-1:0];
         st3_ff <= st_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/qrs_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined divider
// Restoring unsigned division, one quotient bit per stage.
// ----------------------------------------------------------------------------
module qrs_div
   import qrs_pkg::*;
#(
   parameter int UW = 35,
   parameter int VW = 17
) (
   input  wire logic          clock,
   input  wire logic          enable,
   input  wire logic [UW-1:0] dividend,
   input  wire logic [VW-1:0] divisor,
   output logic      [UW-1:0] quotient
);

   localparam int PW = VW + 1;

   logic [UW-1:0] num_ff [UW+1];
   logic [VW-1:0] dv_ff  [UW+1];
   logic [PW-1:0] rem_ff [UW+1];
   logic [UW-1:0] quo_ff [UW+1];

   assign quotient = quo_ff[UW];

   always_ff @(posedge clock) begin
      if (enable) begin
         num_ff[0] <= dividend;
         dv_ff[0]  <= divisor;
         rem_ff[0] <= '0;
         quo_ff[0] <= '0;
      end
   end

   for (genvar i = 0; i < UW; i++) begin : g_stage
      logic [PW-1:0] rem_sh;
      logic          ge;
      assign rem_sh = {rem_ff[i][PW-2:0], num_ff[i][UW-1-i]};
      assign ge     = (rem_sh >= PW'(dv_ff[i]));
      always_ff @(posedge clock) begin
         if (enable) begin
            num_ff[i+1] <= num_ff[i];
            dv_ff[i+1]  <= dv_ff[i];
            rem_ff[i+1] <= ge ? rem_sh - PW'(dv_ff[i]) : rem_sh;
            quo_ff[i+1] <= {quo_ff[i][UW-2:0], ge};
         end
      end
   end

endmodule

`default_nettype wire

// File: hdl/qrs_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Solver back end
// Square root, numerators, two dividers and saturation of the roots.
// ----------------------------------------------------------------------------
module qrs_back
   import qrs_pkg::*;
#(
   parameter int W = 16
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        mid_empty,
   input  wire logic [STATUS_WIDTH+4*W:0]   mid_data,
   output logic                             mid_pop,
   input  wire logic                        out_full,
   output logic                             out_push,
   output logic [2*ROOT_WIDTH+STATUS_WIDTH:0] out_data
);

   localparam int DW = 2 * W + 1;
   localparam int SW = W + 17;
   localparam int XW = 2 * SW;
   localparam int RW = SW + 2;
   localparam int NW = W + 19;
   localparam int UW = W + 19;
   localparam int VW = W + 1;

   function automatic logic [ROOT_WIDTH:0] sat_root(input logic [UW-1:0] q,
                                                    input logic neg);
      logic [63:0] qx;
      logic [ROOT_WIDTH:0] r;
      qx = 64'(q);
      if (neg) begin
         if (qx > ROOT_NEG_LIMIT) begin
            r = {1'b1, ROOT_NEG_LIMIT[ROOT_WIDTH-1:0]};
         end else begin
            r = {1'b0, ROOT_WIDTH'(64'd0 - qx)};
         end
      end else begin
         if (qx > ROOT_POS_LIMIT) begin
            r = {1'b1, ROOT_POS_LIMIT[ROOT_WIDTH-1:0]};
         end else begin
            r = {1'b0, qx[ROOT_WIDTH-1:0]};
         end
      end
      return r;
   endfunction

   logic en;
   assign en      = !out_full;
   assign mid_pop = en && !mid_empty;

   // Square root section.
   logic                sq_v_ff    [SW+1];
   status_type          sq_st_ff   [SW+1];
   logic signed [W-1:0] sq_a_ff    [SW+1];
   logic signed [W-1:0] sq_b_ff    [SW+1];
   logic [DW-1:0]       sq_d_ff    [SW+1];
   logic [SW-1:0]       sq_root_ff [SW+1];
   logic [RW-1:0]       sq_rem_ff  [SW+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff[0] <= 1'b0;
      end else if (en) begin
         sq_v_ff[0] <= mid_pop;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_st_ff[0]   <= status_type'(mid_data[STATUS_WIDTH+4*W:4*W+1]);
         sq_a_ff[0]    <= mid_data[4*W:3*W+1];
         sq_b_ff[0]    <= mid_data[3*W:DW];
         sq_d_ff[0]    <= mid_data[DW-1:0];
         sq_root_ff[0] <= '0;
         sq_rem_ff[0]  <= '0;
      end
   end

   for (genvar i = 0; i < SW; i++) begin : g_sqrt
      logic [XW-1:0] xpad;
      logic [RW-1:0] rem_sh;
      logic [RW-1:0] trial;
      logic          ge;
      assign xpad   = {1'b0, sq_d_ff[i], {(2*ROOT_FRAC){1'b0}}};
      assign rem_sh = {sq_rem_ff[i][RW-3:0], xpad[XW-1-2*i -: 2]};
      assign trial  = {sq_root_ff[i], 2'b01};
      assign ge     = (rem_sh >= trial);
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[i+1] <= 1'b0;
         end else if (en) begin
            sq_v_ff[i+1] <= sq_v_ff[i];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            sq_st_ff[i+1]   <= sq_st_ff[i];
            sq_a_ff[i+1]    <= sq_a_ff[i];
            sq_b_ff[i+1]    <= sq_b_ff[i];
            sq_d_ff[i+1]    <= sq_d_ff[i];
            sq_rem_ff[i+1]  <= ge ? rem_sh - trial : rem_sh;
            sq_root_ff[i+1] <= {sq_root_ff[i][SW-2:0], ge};
         end
      end
   end

   // Rounding, numerators and divider operands.
   logic                r1_v_ff, r2_v_ff;
   status_type          r1_st_ff, r2_st_ff;
   logic signed [W-1:0] r1_a_ff, r1_b_ff;
   logic [SW:0]         r1_s_ff;
   logic signed [NW-1:0] r2_np_ff, r2_nm_ff;
   logic [W-1:0]        r2_ua_ff;
   logic                r2_aneg_ff;
   logic [SW:0]         s_in;
   logic signed [NW-1:0] bsh;
   logic signed [NW-1:0] np_in, nm_in;
   logic [W-1:0]        ua_in;
   logic [UW-1:0]       up_in, um_in;
   logic [UW-1:0]       npu, nmu;
   logic [VW-1:0]       dv_in;

   always_comb begin
      s_in  = (SW+1)'(sq_root_ff[SW])
            + (SW+1)'(sq_rem_ff[SW] > RW'(sq_root_ff[SW]));
      bsh   = NW'(r1_b_ff) <<< ROOT_FRAC;
      np_in = $signed(NW'(r1_s_ff)) - bsh;
      nm_in = -bsh - $signed(NW'(r1_s_ff));
      ua_in = r1_a_ff[W-1] ? W'(-r1_a_ff) : W'(r1_a_ff);
      npu   = UW'(r2_np_ff);
      nmu   = UW'(r2_nm_ff);
      up_in = r2_np_ff[NW-1] ? UW'(r2_ua_ff) - npu : npu + UW'(r2_ua_ff);
      um_in = r2_nm_ff[NW-1] ? UW'(r2_ua_ff) - nmu : nmu + UW'(r2_ua_ff);
      dv_in = {r2_ua_ff, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r1_v_ff <= 1'b0;
         r2_v_ff <= 1'b0;
      end else if (en) begin
         r1_v_ff <= sq_v_ff[SW];
         r2_v_ff <= r1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r1_st_ff   <= sq_st_ff[SW];
         r1_a_ff    <= sq_a_ff[SW];
         r1_b_ff    <= sq_b_ff[SW];
         r1_s_ff    <= s_in;
         r2_st_ff   <= r1_st_ff;
         r2_np_ff   <= np_in;
         r2_nm_ff   <= nm_in;
         r2_ua_ff   <= ua_in;
         r2_aneg_ff <= r1_a_ff[W-1];
      end
   end

   // Division section.
   logic          dq_v_ff    [UW+2];
   status_type    dq_st_ff   [UW+2];
   logic          dq_negp_ff [UW+2];
   logic          dq_negm_ff [UW+2];
   logic [UW-1:0] q_plus, q_minus;

   qrs_div #(.UW(UW), .VW(VW)) u_div_plus (
      .clock    (clock),
      .enable   (en),
      .dividend (up_in),
      .divisor  (dv_in),
      .quotient (q_plus)
   );

   qrs_div #(.UW(UW), .VW(VW)) u_div_minus (
      .clock    (clock),
      .enable   (en),
      .dividend (um_in),
      .divisor  (dv_in),
      .quotient (q_minus)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         dq_v_ff[0] <= 1'b0;
      end else if (en) begin
         dq_v_ff[0] <= r2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dq_st_ff[0]   <= r2_st_ff;
         dq_negp_ff[0] <= r2_np_ff[NW-1] ^ r2_aneg_ff;
         dq_negm_ff[0] <= r2_nm_ff[NW-1] ^ r2_aneg_ff;
      end
   end

   for (genvar i = 0; i < UW; i++) begin : g_side
      always_ff @(posedge clock) begin
         if (reset) begin
            dq_v_ff[i+1] <= 1'b0;
         end else if (en) begin
            dq_v_ff[i+1] <= dq_v_ff[i];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            dq_st_ff[i+1]   <= dq_st_ff[i];
            dq_negp_ff[i+1] <= dq_negp_ff[i];
            dq_negm_ff[i+1] <= dq_negm_ff[i];
         end
      end
   end

   // Saturation and result assembly.
   logic [ROOT_WIDTH:0] rp, rm;
   logic                real_roots;

   always_comb begin
      rp         = sat_root(q_plus, dq_negp_ff[UW]);
      rm         = sat_root(q_minus, dq_negm_ff[UW]);
      real_roots = (dq_st_ff[UW] == ST_REAL);
      out_push   = en && dq_v_ff[UW];
      if (real_roots) begin
         out_data = {rp[ROOT_WIDTH-1:0], rm[ROOT_WIDTH-1:0], dq_st_ff[UW],
                     rp[ROOT_WIDTH] | rm[ROOT_WIDTH]};
      end else begin
         out_data = {{(2*ROOT_WIDTH){1'b0}}, dq_st_ff[UW], 1'b0};
      end
   end

endmodule

`default_nettype wire

// File: hdl/quadratic_root_solver.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Quadratic root solver
// Solves a*x^2 + b*x + c = 0 for real roots in fixed point.
//
// Coefficients enter as signed Q8.8 (COEF_WIDTH bits) through a queue-style
// port: a transaction is taken when push is high and full is low. Results
// leave the same way: while empty is low the oldest result is on the rsp_
// ports, and it is taken when pop is high. Each result holds both roots as
// signed Q16.16, saturated, a status code and a saturation flag.
// One transaction is accepted per cycle while full is low. The bit-per-stage
// square root and the two bit-per-stage dividers, which run side by side,
// set most of the pipeline depth. A two-entry queue separates the front end
// from the back end and another holds finished results, so a receiver that
// stops popping stalls the back end first and then the front end, which
// raises full.
// No transaction is lost or repeated. Reset empties both queues and the
// pipelines; nothing else needs to be set up.
// ----------------------------------------------------------------------------
module quadratic_root_solver
   import qrs_pkg::*;
#(
   parameter int COEF_WIDTH = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          push,
   output logic                               full,
   input  wire logic signed [COEF_WIDTH-1:0]  req_coef_a,
   input  wire logic signed [COEF_WIDTH-1:0]  req_coef_b,
   input  wire logic signed [COEF_WIDTH-1:0]  req_coef_c,
   output logic                               empty,
   input  wire logic                          pop,
   output logic signed [ROOT_WIDTH-1:0]       rsp_root_plus,
   output logic signed [ROOT_WIDTH-1:0]       rsp_root_minus,
   output logic [STATUS_WIDTH-1:0]            rsp_status,
   output logic                               rsp_saturated
);

   localparam int MW = STATUS_WIDTH + 4 * COEF_WIDTH + 1;
   localparam int OW = 2 * ROOT_WIDTH + STATUS_WIDTH + 1;

   logic          accept;
   logic          front_valid;
   logic [MW-1:0] front_data;
   logic          mid_full, mid_empty, mid_pop;
   logic [MW-1:0] mid_data;
   logic          out_full, out_push;
   logic [OW-1:0] back_data;
   logic [OW-1:0] rsp_data;

   assign accept = push && !full;

   qrs_front #(.W(COEF_WIDTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .coef_a    (req_coef_a),
      .coef_b    (req_coef_b),
      .coef_c    (req_coef_c),
      .full      (full),
      .down_full (mid_full),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   qrs_fifo #(.WIDTH(MW)) u_mid_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_data (front_data),
      .pop       (mid_pop),
      .pop_data  (mid_data),
      .empty     (mid_empty),
      .full      (mid_full)
   );

   qrs_back #(.W(COEF_WIDTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty),
      .mid_data  (mid_data),
      .mid_pop   (mid_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_data  (back_data)
   );

   qrs_fifo #(.WIDTH(OW)) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (back_data),
      .pop       (pop && !empty),
      .pop_data  (rsp_data),
      .empty     (empty),
      .full      (out_full)
   );

   assign rsp_root_plus  = rsp_data[OW-1:ROOT_WIDTH+STATUS_WIDTH+1];
   assign rsp_root_minus = rsp_data[ROOT_WIDTH+STATUS_WIDTH:STATUS_WIDTH+1];
   assign rsp_status     = rsp_data[STATUS_WIDTH:1];
   assign rsp_saturated  = rsp_data[0];

endmodule

`default_nettype wire

// File: tb/sv/qrs_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Quadratic root solver checker
// Watches both queue ports of the solver, computes the expected roots,
// status and saturation flag of every accepted coefficient set, and compares
// each popped result with the oldest expected one, field by field.
// ----------------------------------------------------------------------------
module qrs_checker
   import qrs_pkg::*;
#(
   parameter int COEF_WIDTH = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          push,
   input  wire logic                          full,
   input  wire logic signed [COEF_WIDTH-1:0]  req_coef_a,
   input  wire logic signed [COEF_WIDTH-1:0]  req_coef_b,
   input  wire logic signed [COEF_WIDTH-1:0]  req_coef_c,
   input  wire logic                          empty,
   input  wire logic                          pop,
   input  wire logic signed [ROOT_WIDTH-1:0]  rsp_root_plus,
   input  wire logic signed [ROOT_WIDTH-1:0]  rsp_root_minus,
   input  wire logic [STATUS_WIDTH-1:0]       rsp_status,
   input  wire logic                          rsp_saturated,
   output int                                 pending,
   output int                                 failures
);

   typedef struct {
      logic signed [ROOT_WIDTH-1:0] root_plus;
      logic signed [ROOT_WIDTH-1:0] root_minus;
      status_type                   status;
      logic                         saturated;
   } roots_type;

   roots_type expected_roots[$];

   function automatic logic signed [63:0] scaled_quotient(input logic signed [63:0] num,
                                                          input logic signed [63:0] den,
                                                          inout logic sat);
      logic [63:0] un;
      logic [63:0] ud;
      logic [63:0] q;
      un = num < 0 ? -num : num;
      ud = den < 0 ? -den : den;
      q = (un + ud) / (ud << 1);
      if ((num < 0) != (den < 0)) begin
         if (q > 64'd2147483648) begin
            sat = 1'b1;
            return -64'sd2147483648;
         end
         return -$signed(q);
      end
      if (q > 64'd2147483647) begin
         sat = 1'b1;
         return 64'sd2147483647;
      end
      return $signed(q);
   endfunction

   function automatic roots_type solve_quadratic(input logic signed [COEF_WIDTH-1:0] a_in,
                                                 input logic signed [COEF_WIDTH-1:0] b_in,
                                                 input logic signed [COEF_WIDTH-1:0] c_in);
      roots_type r;
      logic signed [127:0] a;
      logic signed [127:0] b;
      logic signed [127:0] c;
      logic signed [127:0] disc;
      logic [127:0] x;
      logic [127:0] root;
      logic [127:0] trial;
      logic signed [63:0] neg_b;
      logic sat;
      a = a_in;
      b = b_in;
      c = c_in;
      sat = 1'b0;
      r.root_plus = '0;
      r.root_minus = '0;
      r.saturated = 1'b0;
      r.status = ST_REAL;
      if (a == 0) begin
         r.status = ST_A_ZERO;
         return r;
      end
      disc = b * b - 4 * a * c;
      if (disc < 0) begin
         r.status = ST_NEG_DISC;
         return r;
      end
      x = disc << 32;
      root = '0;
      for (int i = 40; i >= 0; i--) begin
         trial = root | (128'd1 << i);
         if (trial * trial <= x) root = trial;
      end
      if (x - root * root > root) root = root + 1;
      neg_b = -(64'(b) <<< 16);
      r.root_plus = ROOT_WIDTH'(scaled_quotient(neg_b + $signed(64'(root)), 64'(a), sat));
      r.root_minus = ROOT_WIDTH'(scaled_quotient(neg_b - $signed(64'(root)), 64'(a), sat));
      r.saturated = sat;
      return r;
   endfunction

   assign pending = expected_roots.size();

   always_ff @(posedge clock) begin
      roots_type exp_r;
      if (reset) begin
         failures <= 0;
      end else begin
         if (push && !full) begin
            expected_roots.push_back(solve_quadratic(req_coef_a, req_coef_b, req_coef_c));
         end
         if (pop && !empty) begin
            if (expected_roots.size() == 0) begin
               if (failures < 10) $display("Unexpected result transaction at %0t", $realtime);
               failures <= failures + 1;
            end else begin
               exp_r = expected_roots.pop_front();
               if (rsp_root_plus !== exp_r.root_plus || rsp_root_minus !== exp_r.root_minus
                   || rsp_status !== exp_r.status || rsp_saturated !== exp_r.saturated) begin
                  if (failures < 10)
                     $display("Mismatch at %0t: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                        $realtime, exp_r.root_plus, exp_r.root_minus, exp_r.status,
                        exp_r.saturated, rsp_root_plus, rsp_root_minus, rsp_status,
                        rsp_saturated);
                  failures <= failures + 1;
               end
            end
         end
      end
   end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Quadratic root solver testbench
// Drives directed and random coefficient sets into the solver with random
// gaps and result stalls, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module tb;
   import qrs_pkg::*;

   localparam int CW = 16;

   logic clock;
   logic reset;
   logic push;
   logic full;
   logic signed [CW-1:0] req_coef_a;
   logic signed [CW-1:0] req_coef_b;
   logic signed [CW-1:0] req_coef_c;
   logic empty;
   logic pop;
   logic signed [ROOT_WIDTH-1:0] rsp_root_plus;
   logic signed [ROOT_WIDTH-1:0] rsp_root_minus;
   logic [STATUS_WIDTH-1:0] rsp_status;
   logic rsp_saturated;
   int pending;
   int failures;
   bit no_gaps;

   quadratic_root_solver #(.COEF_WIDTH(CW)) DUT (.*);
   qrs_checker #(.COEF_WIDTH(CW)) u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int idle_length();
      if (no_gaps || $urandom_range(0, 2) == 0) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic send_coefs(input logic [CW-1:0] a, input logic [CW-1:0] b,
                             input logic [CW-1:0] c);
      int gap;
      gap = idle_length();
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_coef_a <= a;
      req_coef_b <= b;
      req_coef_c <= c;
      do @(posedge clock); while (full);
   endtask

   function automatic logic [CW-1:0] small_coef();
      return CW'($signed($urandom_range(0, 2047)) - 1024);
   endfunction

   initial begin
      int gap;
      pop = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = idle_length();
         if (gap > 0) begin
            pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
      end
   end

   initial begin
      int kind;
      reset = 1'b1;
      push = 1'b0;
      req_coef_a = '0;
      req_coef_b = '0;
      req_coef_c = '0;
      no_gaps = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_coefs(16'h0000, 16'h0000, 16'h0000);
      send_coefs(16'h0000, 16'h7fff, 16'h8000);
      send_coefs(16'h0100, 16'h0000, 16'h0100);
      send_coefs(16'h0100, 16'h0000, 16'hff00);
      send_coefs(16'h0100, 16'hfe00, 16'h0100);
      send_coefs(16'h7fff, 16'h7fff, 16'h7fff);
      send_coefs(16'h8000, 16'h8000, 16'h8000);
      send_coefs(16'h8000, 16'h7fff, 16'h7fff);
      send_coefs(16'h7fff, 16'h8000, 16'h8000);
      send_coefs(16'h0001, 16'h8000, 16'h0000);
      send_coefs(16'h0001, 16'h7fff, 16'h0000);
      send_coefs(16'hffff, 16'h8000, 16'h7fff);
      send_coefs(16'h0001, 16'h0000, 16'h8000);
      send_coefs(16'hffff, 16'h0000, 16'h7fff);
      send_coefs(16'h0001, 16'h0001, 16'h0001);
      send_coefs(16'hffff, 16'hffff, 16'hffff);
      send_coefs(16'h0300, 16'h0500, 16'hfe00);
      send_coefs(16'hff00, 16'h0100, 16'h7fff);
      push <= 1'b0;
      while (pending != 0) @(posedge clock);
      for (int i = 0; i < 900; i++) begin
         no_gaps = (i / 150) % 3 == 2;
         kind = $urandom_range(0, 9);
         if (kind < 4)
            send_coefs(CW'($urandom), CW'($urandom), CW'($urandom));
         else if (kind < 7)
            send_coefs(small_coef(), CW'($urandom), small_coef());
         else if (kind < 8)
            send_coefs(CW'($urandom_range(0, 3) - 2), CW'($urandom), CW'($urandom));
         else if (kind < 9)
            send_coefs('0, CW'($urandom), CW'($urandom));
         else
            send_coefs(CW'($urandom), small_coef(), CW'($urandom));
      end
      push <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (failures == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

   initial begin
      #20ms;
      $display("tb: FAIL");
      $finish;
   end

endmodule

// File: sim.f
hdl/qrs_pkg.sv
hdl/qrs_fifo.sv
hdl/qrs_front.sv
hdl/qrs_div.sv
hdl/qrs_back.sv
hdl/quadratic_root_solver.sv
tb/sv/qrs_checker.sv
tb/sv/tb.sv
